FILE: sv/fgt_pkg.sv
// Shared types and constants for the feed gap tracker.
`timescale 1ns / 1ps
`default_nettype none
package fgt_pkg;

	localparam int SYMBOL_COUNT = 32;
	localparam int SLOT_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam logic [7:0] ADD_ORDER_RESET = 8'd65;

	typedef enum logic {
		ACT_PROCESS = 1'b0,
		ACT_READ    = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [31:0]        seq_number;
		logic [7:0]         msg_kind;
		logic [63:0]        exch_time_ns;
		logic [31:0]        symbol_index;
		logic signed [63:0] price_ticks_in;
		logic [31:0]        quantity_in;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        message_count;
		logic [63:0]        gap_event_count;
		logic [63:0]        missing_total;
		logic [63:0]        duplicate_count;
		logic signed [63:0] entry_price;
		logic [31:0]        entry_quantity;
		logic [63:0]        entry_time_ns;
		logic [31:0]        entry_updates;
	} out_item_t;

	// One symbol table row.
	typedef struct packed {
		logic signed [63:0] price;
		logic [31:0]        qty;
		logic [63:0]        time_ns;
		logic [31:0]        updates;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [63:0] msg;
		logic [63:0] gap;
		logic [63:0] missing;
		logic [63:0] dup;
	} cnt_t;

	typedef struct packed {
		logic        commit;
		logic [31:0] seq;
	} seq_req_t;

endpackage
`default_nettype wire

FILE: sv/fgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fgt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire                                        clk,
	input  wire                                        we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                            wdata,
	input  wire                                        re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: sv/fgt_seq.sv
// Sequence number check and the global message counters.
`timescale 1ns / 1ps
`default_nettype none
module fgt_seq (
	input  wire              clk,
	input  wire              arst_n,
	input  fgt_pkg::seq_req_t req,
	output fgt_pkg::cnt_t    cnt_cur,
	output fgt_pkg::cnt_t    cnt_next
);
	import fgt_pkg::*;

	logic [31:0] expected_q;
	logic        first_q;
	cnt_t        cnt_q;
	logic        jump_fwd;
	logic        jump_back;
	logic [31:0] diff;

	// first message after reset skips the check
	assign jump_fwd  = !first_q && (req.seq > expected_q);
	assign jump_back = !first_q && (req.seq < expected_q);
	assign diff      = req.seq - expected_q;

	always_comb begin
		cnt_next.msg     = cnt_q.msg + 64'd1;
		cnt_next.gap     = cnt_q.gap + {63'd0, jump_fwd};
		cnt_next.missing = cnt_q.missing + (jump_fwd ? {32'd0, diff} : 64'd0);
		cnt_next.dup     = cnt_q.dup + {63'd0, jump_back};
	end

	assign cnt_cur = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			first_q    <= 1'b1;
			cnt_q      <= '0;
		end else if (req.commit) begin
			expected_q <= req.seq + 32'd1;
			first_q    <= 1'b0;
			cnt_q      <= cnt_next;
		end
	end

endmodule
`default_nettype wire

FILE: sv/feed_gap_tracker_symbol_table.sv
// Feed gap tracker: sequence gap counters plus a per-symbol last-order table.
//
// Input channel item/item_valid/item_stall carries one message (action
// ACT_PROCESS) or one table read (action ACT_READ). Output channel
// result/result_valid/result_stall returns one result per item: the four
// global counters and the addressed table entry, both as they stand after
// the item. The add-order type code is written through cfg_we/cfg_wdata.
// An accepted item is registered in the read/modify stage and its result in
// the output register. Items are taken at one per cycle while item_stall is
// low: the table RAM is read at accept and written as the item leaves that
// stage; a write to the slot the next item reads is forwarded to it.
// When result_stall holds a result, one further item can sit in the
// read/modify stage; after that item_stall rises until the result is taken.
// Reset clears the counters, the expected sequence state, the output valid
// and the per-entry valid flags, so every table entry reads zero until its
// first add-order; no clearing sweep is needed and items are taken at once.
// The add-order code resets to 65.
`timescale 1ns / 1ps
`default_nettype none
module feed_gap_tracker_symbol_table (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_stall,
	input  fgt_pkg::in_item_t  item,
	output logic               result_valid,
	input  wire                result_stall,
	output fgt_pkg::out_item_t result,
	input  wire                cfg_we,
	input  wire [7:0]          cfg_wdata
);
	import fgt_pkg::*;

	logic [7:0]              add_code_q;
	logic                    s1_valid_q;
	in_item_t                item_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic                    fwd_s1;
	entry_t                  fwd_data_s1;
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic                    result_valid_q;
	out_item_t               result_q;

	logic              accept;
	logic              s1_done;
	logic [SLOT_W-1:0] slot_in;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            cur_entry;
	entry_t            new_entry;
	logic              is_add;
	logic              wr_en;
	seq_req_t          seq_req;
	cnt_t              cnt_cur;
	cnt_t              cnt_next;
	out_item_t         res_d;

	assign slot_in    = SLOT_W'(item.symbol_index % SYMBOL_COUNT);
	assign s1_done    = s1_valid_q && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid_q && !s1_done;
	assign accept     = item_valid && !item_stall;

	assign is_add = (item_s1.action == ACT_PROCESS) && (item_s1.msg_kind == add_code_q);
	assign wr_en  = s1_done && is_add;

	fgt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_s1),
		.wdata (new_entry),
		.re    (accept),
		.raddr (slot_in),
		.rdata (ram_rdata)
	);

	// forwarded write wins, then entries never written read as zero
	always_comb begin
		if (fwd_s1) begin
			cur_entry = fwd_data_s1;
		end else if (vld_q[slot_s1]) begin
			cur_entry = entry_t'(ram_rdata);
		end else begin
			cur_entry = '0;
		end
		new_entry.price   = item_s1.price_ticks_in;
		new_entry.qty     = item_s1.quantity_in;
		new_entry.time_ns = item_s1.exch_time_ns;
		new_entry.updates = cur_entry.updates + 32'd1;
	end

	assign seq_req.commit = s1_done && (item_s1.action == ACT_PROCESS);
	assign seq_req.seq    = item_s1.seq_number;

	fgt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (seq_req),
		.cnt_cur  (cnt_cur),
		.cnt_next (cnt_next)
	);

	always_comb begin
		cnt_t   cnt_sel;
		entry_t ent_sel;
		cnt_sel = (item_s1.action == ACT_PROCESS) ? cnt_next : cnt_cur;
		ent_sel = is_add ? new_entry : cur_entry;
		res_d.message_count   = cnt_sel.msg;
		res_d.gap_event_count = cnt_sel.gap;
		res_d.missing_total   = cnt_sel.missing;
		res_d.duplicate_count = cnt_sel.dup;
		res_d.entry_price     = ent_sel.price;
		res_d.entry_quantity  = ent_sel.qty;
		res_d.entry_time_ns   = ent_sel.time_ns;
		res_d.entry_updates   = ent_sel.updates;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_code_q     <= ADD_ORDER_RESET;
			s1_valid_q     <= 1'b0;
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				add_code_q <= cfg_wdata;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[slot_s1] <= 1'b1;
			end
			if (s1_done) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			slot_s1     <= slot_in;
			fwd_s1      <= wr_en && (slot_in == slot_s1);
			fwd_data_s1 <= new_entry;
		end
		if (s1_done) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

FILE: sv/fgt_checker.sv
// Port-level checks for the feed gap tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fgt_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                item_stall,
	input wire                result_valid,
	input wire                result_stall,
	input fgt_pkg::out_item_t result
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// input backs up only behind a held result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a held result");

	a_gap_le_msg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.gap_event_count <= result.message_count)
		else $error("gap events exceed message count");

	a_dup_le_msg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.duplicate_count + result.gap_event_count
			<= result.message_count)
		else $error("duplicates plus gaps exceed message count");

endmodule

bind feed_gap_tracker_symbol_table fgt_checker u_fgt_checker (.*);
`default_nettype wire

FILE: verif/feed_gap_tracker_symbol_table_tb.sv
// Testbench for feed_gap_tracker_symbol_table: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module feed_gap_tracker_symbol_table_tb;
	import fgt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PRINT_CAP = 60;
	localparam int PHASE_ITEMS = 295;
	localparam logic [7:0] CODE_MIN = 8'h00;
	localparam logic [7:0] CODE_MAX = 8'hFF;
	localparam logic [7:0] KIND_OTHER = 8'h44;
	localparam logic [63:0] PRICE_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] PRICE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_item_t feed_item;
	logic result_valid;
	logic result_stall;
	out_item_t result_bus;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	feed_gap_tracker_symbol_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(feed_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_bus),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [7:0] add_code;
	logic [31:0] next_seq;
	logic awaiting_first;
	logic [63:0] msg_total;
	logic [63:0] gap_jumps;
	logic [63:0] missing_seqs;
	logic [63:0] dup_total;
	entry_t sym_table [SYMBOL_COUNT];

	out_item_t expected_results [$];
	int mismatches = 0;
	int cycles = 0;

	// sender and receiver idling controls
	int gap_max = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_run = 0;
	int hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: long hold-off when requested, otherwise random stall runs
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			result_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run = stall_run - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_run = $urandom_range(5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < PRINT_CAP)
			$display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input out_item_t got, input out_item_t want);
		if (got.message_count !== want.message_count)
			report_mismatch("message_count", got.message_count, want.message_count);
		if (got.gap_event_count !== want.gap_event_count)
			report_mismatch("gap_event_count", got.gap_event_count, want.gap_event_count);
		if (got.missing_total !== want.missing_total)
			report_mismatch("missing_total", got.missing_total, want.missing_total);
		if (got.duplicate_count !== want.duplicate_count)
			report_mismatch("duplicate_count", got.duplicate_count, want.duplicate_count);
		if (got.entry_price !== want.entry_price)
			report_mismatch("entry_price", got.entry_price, want.entry_price);
		if (got.entry_quantity !== want.entry_quantity)
			report_mismatch("entry_quantity", {32'd0, got.entry_quantity},
				{32'd0, want.entry_quantity});
		if (got.entry_time_ns !== want.entry_time_ns)
			report_mismatch("entry_time_ns", got.entry_time_ns, want.entry_time_ns);
		if (got.entry_updates !== want.entry_updates)
			report_mismatch("entry_updates", {32'd0, got.entry_updates},
				{32'd0, want.entry_updates});
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0)
				report_mismatch("result with nothing expected", result_bus.message_count, 64'd0);
			else
				check_result(result_bus, expected_results.pop_front());
		end
	end

	function automatic void tracker_reset();
		add_code = ADD_ORDER_RESET;
		next_seq = '0;
		awaiting_first = 1'b1;
		msg_total = '0;
		gap_jumps = '0;
		missing_seqs = '0;
		dup_total = '0;
		for (int i = 0; i < SYMBOL_COUNT; i++)
			sym_table[i] = '0;
	endfunction

	function automatic out_item_t predict_tracker(input in_item_t x);
		out_item_t r;
		int unsigned slot;
		slot = x.symbol_index % SYMBOL_COUNT;
		if (x.action == ACT_PROCESS) begin
			if (!awaiting_first) begin
				if (x.seq_number > next_seq) begin
					missing_seqs += 64'(x.seq_number - next_seq);
					gap_jumps += 64'd1;
				end else if (x.seq_number < next_seq) begin
					dup_total += 64'd1;
				end
			end
			next_seq = x.seq_number + 32'd1;
			awaiting_first = 1'b0;
			msg_total += 64'd1;
			if (x.msg_kind == add_code) begin
				sym_table[slot].price = x.price_ticks_in;
				sym_table[slot].qty = x.quantity_in;
				sym_table[slot].time_ns = x.exch_time_ns;
				sym_table[slot].updates = sym_table[slot].updates + 32'd1;
			end
		end
		r.message_count = msg_total;
		r.gap_event_count = gap_jumps;
		r.missing_total = missing_seqs;
		r.duplicate_count = dup_total;
		r.entry_price = sym_table[slot].price;
		r.entry_quantity = sym_table[slot].qty;
		r.entry_time_ns = sym_table[slot].time_ns;
		r.entry_updates = sym_table[slot].updates;
		return r;
	endfunction

	function automatic in_item_t make_msg(input action_t act, input logic [31:0] seq,
			input logic [7:0] kind, input logic [63:0] ts, input logic [31:0] sym,
			input logic [63:0] price, input logic [31:0] qty);
		in_item_t x;
		x.action = act;
		x.seq_number = seq;
		x.msg_kind = kind;
		x.exch_time_ns = ts;
		x.symbol_index = sym;
		x.price_ticks_in = price;
		x.quantity_in = qty;
		return x;
	endfunction

	// mostly in-order add-orders on a few symbols, with gaps, duplicates and noise
	function automatic in_item_t random_item();
		in_item_t x;
		int unsigned pick;
		x.action = ($urandom_range(99) < 15) ? ACT_READ : ACT_PROCESS;
		pick = $urandom_range(99);
		if (pick < 70)
			x.seq_number = next_seq;
		else if (pick < 80)
			x.seq_number = next_seq + $urandom_range(1, 5);
		else if (pick < 88)
			x.seq_number = next_seq - $urandom_range(1, 3);
		else if (pick < 95)
			x.seq_number = $urandom();
		else
			x.seq_number = 32'hFFFF_FFF0 + $urandom_range(15);
		pick = $urandom_range(99);
		if (pick < 70)
			x.msg_kind = add_code;
		else if (pick < 80)
			x.msg_kind = $urandom_range(1) ? add_code + 8'd1 : add_code - 8'd1;
		else
			x.msg_kind = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 60)
			x.symbol_index = $urandom_range(7);
		else if (pick < 85)
			x.symbol_index = $urandom_range(SYMBOL_COUNT - 1);
		else
			x.symbol_index = $urandom();
		pick = $urandom_range(99);
		if (pick < 3)
			x.price_ticks_in = PRICE_MIN;
		else if (pick < 6)
			x.price_ticks_in = PRICE_MAX;
		else if (pick < 8)
			x.price_ticks_in = '1;
		else if (pick < 10)
			x.price_ticks_in = '0;
		else
			x.price_ticks_in = {$urandom(), $urandom()};
		x.exch_time_ns = {$urandom(), $urandom()};
		x.quantity_in = $urandom();
		return x;
	endfunction

	task automatic push_item(input in_item_t x);
		item_valid <= 1'b1;
		feed_item <= x;
		do @(posedge clk); while (item_stall);
		expected_results.insert(expected_results.size(), predict_tracker(x));
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				item_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_add_code(input logic [7:0] code);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		add_code = code;
	endtask

	// reads before any message: table and counters all zero, junk fields ignored
	task automatic test_reset_state();
		push_item(make_msg(ACT_READ, '1, ADD_ORDER_RESET, '1, 32'd0, PRICE_MAX, '1));
		push_item(make_msg(ACT_READ, 32'd7, ADD_ORDER_RESET, '1, 32'd31, PRICE_MIN, '1));
		push_item(make_msg(ACT_READ, '0, KIND_OTHER, '0, '1, '0, '0));
		drain_results();
	endtask

	task automatic test_sequence_tracking();
		// first message only arms the tracker; seq+1 wraps to zero
		push_item(make_msg(ACT_PROCESS, '1, KIND_OTHER, 64'd1, 32'd3, 64'd5, 32'd1));
		push_item(make_msg(ACT_READ, 32'd100, KIND_OTHER, '0, 32'd3, '0, '0));
		push_item(make_msg(ACT_PROCESS, 32'd0, KIND_OTHER, 64'd2, 32'd3, 64'd5, 32'd1));
		push_item(make_msg(ACT_PROCESS, 32'd10, KIND_OTHER, 64'd3, 32'd3, 64'd5, 32'd1));
		push_item(make_msg(ACT_PROCESS, 32'd3, KIND_OTHER, 64'd4, 32'd3, 64'd5, 32'd1));
		push_item(make_msg(ACT_PROCESS, 32'd4, KIND_OTHER, 64'd5, 32'd3, 64'd5, 32'd1));
		push_item(make_msg(ACT_PROCESS, '1, KIND_OTHER, 64'd6, 32'd3, 64'd5, 32'd1));
		push_item(make_msg(ACT_PROCESS, 32'd0, KIND_OTHER, 64'd7, 32'd3, 64'd5, 32'd1));
		push_item(make_msg(ACT_PROCESS, 32'd0, KIND_OTHER, 64'd8, 32'd3, 64'd5, 32'd1));
		drain_results();
	endtask

	task automatic test_symbol_table();
		push_item(make_msg(ACT_PROCESS, 32'd1, ADD_ORDER_RESET, '1, '1, PRICE_MIN, '1));
		push_item(make_msg(ACT_PROCESS, 32'd2, ADD_ORDER_RESET, '0, 32'd32, PRICE_MAX, '0));
		push_item(make_msg(ACT_READ, '0, '0, '0, 32'd31, '0, '0));
		// non-add-order leaves the entry but still reports it
		push_item(make_msg(ACT_PROCESS, 32'd3, KIND_OTHER, 64'd9, 32'd63, 64'd9, 32'd9));
		push_item(make_msg(ACT_PROCESS, 32'd4, ADD_ORDER_RESET - 8'd1, 64'd9, 32'd0, 64'd9, 32'd9));
		push_item(make_msg(ACT_PROCESS, 32'd5, ADD_ORDER_RESET, 64'd11, 32'd64, '1, 32'd12));
		push_item(make_msg(ACT_READ, '1, '1, '1, 32'd0, '1, '1));
		drain_results();
	endtask

	task automatic test_add_code_config();
		write_add_code(CODE_MIN);
		push_item(make_msg(ACT_PROCESS, 32'd6, CODE_MIN, 64'd20, 32'd5, 64'd21, 32'd22));
		push_item(make_msg(ACT_PROCESS, 32'd7, ADD_ORDER_RESET, 64'd30, 32'd5, 64'd31, 32'd32));
		write_add_code(CODE_MAX);
		push_item(make_msg(ACT_PROCESS, 32'd8, CODE_MAX, 64'd40, 32'd6, 64'd41, 32'd42));
		push_item(make_msg(ACT_PROCESS, 32'd9, CODE_MIN, 64'd50, 32'd6, 64'd51, 32'd52));
		drain_results();
	endtask

	task automatic test_random_phases();
		logic [7:0] codes [6];
		int gaps [6];
		int stalls [6];
		codes = '{8'($urandom_range(255)), CODE_MIN, CODE_MAX, ADD_ORDER_RESET,
			8'($urandom_range(255)), 8'($urandom_range(255))};
		gaps = '{0, 3, 8, 2, 0, 5};
		stalls = '{0, 30, 10, 50, 0, 20};
		for (int p = 0; p < 6; p++) begin
			write_add_code(codes[p]);
			gap_max = gaps[p];
			stall_pct = stalls[p];
			burst_left = 0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_item(random_item());
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		gap_max = 0;
		stall_pct = 0;
		// receiver holds off long enough that the input side backs up
		hold_cycles = 400;
		for (int i = 0; i < 120; i++)
			push_item(random_item());
		// sender pauses until everything is back, then resumes with idling
		drain_results();
		gap_max = 4;
		stall_pct = 25;
		for (int i = 0; i < 60; i++)
			push_item(random_item());
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		feed_item <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		tracker_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stall_pct = 20;
		gap_max = 3;
		test_reset_state();
		test_sequence_tracking();
		test_symbol_table();
		test_add_code_config();
		test_random_phases();
		test_backpressure();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
